@@ hdl/stcs_pkg.sv @@
package stcs_pkg;

    localparam int COUNT_BITS = 32;
    localparam int DEPTH_BITS = 16;
    localparam int QDEPTH     = 2;
    localparam int QPTR_BITS  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_W      = 8'h77;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    typedef struct packed {
        logic [31:0] line_total;
        logic [31:0] complexity;
        logic [15:0] nest_peak;
    } result_t;

    // classified character handed from front to back
    typedef struct packed {
        logic [1:0] hits;
        logic       newline;
        logic       open;
        logic       close;
        logic       last;
    } cls_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_stat_t;

endpackage

@@ hdl/stcs_front.sv @@
module stcs_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    input  stcs_pkg::char_t      char_req,
    input  stcs_pkg::q_stat_t    q_stat,
    output logic                 push,
    output stcs_pkg::cls_t       push_data
);

    logic [47:0] hist_reg;
    logic [47:0] hist_next;
    logic        andand_reg;
    logic        andand_next;
    logic        oror_reg;
    logic        oror_next;

    logic [7:0] c;
    logic [7:0] w0, w1, w2, w3, w4, w5;
    logic       kw_if, kw_elseif, kw_other;
    logic       hit_and, hit_or;

    assign push = char_valid && !q_stat.full;

    always_comb
    begin
        c  = char_req.ch;
        w0 = hist_reg[47:40];
        w1 = hist_reg[39:32];
        w2 = hist_reg[31:24];
        w3 = hist_reg[23:16];
        w4 = hist_reg[15:8];
        w5 = hist_reg[7:0];

        kw_if     = (w5 == stcs_pkg::CH_I) && (c == stcs_pkg::CH_F);
        kw_elseif = (w0 == stcs_pkg::CH_E) && (w1 == stcs_pkg::CH_L) &&
                    (w2 == stcs_pkg::CH_S) && (w3 == stcs_pkg::CH_E) &&
                    (w4 == stcs_pkg::CH_SPACE) && kw_if;

        hit_and = (c == stcs_pkg::CH_AMP) && (w5 == stcs_pkg::CH_AMP) && !andand_reg;
        hit_or  = (c == stcs_pkg::CH_BAR) && (w5 == stcs_pkg::CH_BAR) && !oror_reg;

        kw_other = ((w4 == stcs_pkg::CH_F) && (w5 == stcs_pkg::CH_O) &&
                    (c == stcs_pkg::CH_R)) ||
                   ((w2 == stcs_pkg::CH_W) && (w3 == stcs_pkg::CH_H) &&
                    (w4 == stcs_pkg::CH_I) && (w5 == stcs_pkg::CH_L) &&
                    (c == stcs_pkg::CH_E)) ||
                   ((w3 == stcs_pkg::CH_C) && (w4 == stcs_pkg::CH_A) &&
                    (w5 == stcs_pkg::CH_S) && (c == stcs_pkg::CH_E)) ||
                   ((w2 == stcs_pkg::CH_C) && (w3 == stcs_pkg::CH_A) &&
                    (w4 == stcs_pkg::CH_T) && (w5 == stcs_pkg::CH_C) &&
                    (c == stcs_pkg::CH_H)) ||
                   (c == stcs_pkg::CH_QMARK) || hit_and || hit_or;

        // "else if" ends in 'f', so it always comes with "if" and nothing else
        push_data.hits    = kw_elseif ? 2'd2 : {1'b0, kw_if | kw_other};
        push_data.newline = (c == stcs_pkg::CH_NL);
        push_data.open    = (c == stcs_pkg::CH_LBRACE);
        push_data.close   = (c == stcs_pkg::CH_RBRACE);
        push_data.last    = char_req.last;

        hist_next   = hist_reg;
        andand_next = andand_reg;
        oror_next   = oror_reg;
        if (push)
        begin
            if (char_req.last)
            begin
                hist_next   = '0;
                andand_next = 1'b0;
                oror_next   = 1'b0;
            end
            else
            begin
                hist_next   = {hist_reg[39:0], c};
                andand_next = hit_and;
                oror_next   = hit_or;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg   <= '0;
            andand_reg <= 1'b0;
            oror_reg   <= 1'b0;
        end
        else
        begin
            hist_reg   <= hist_next;
            andand_reg <= andand_next;
            oror_reg   <= oror_next;
        end
    end

    as_no_double_and: assert property (@(posedge clk) disable iff (!rst_n)
        andand_reg |-> hist_reg[7:0] == stcs_pkg::CH_AMP)
        else $error("andand block set without '&' in history");

endmodule

@@ hdl/stcs_queue.sv @@
module stcs_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  stcs_pkg::cls_t       push_data,
    input  logic                 pop,
    output stcs_pkg::cls_t       head,
    output stcs_pkg::q_stat_t    q_stat
);

    stcs_pkg::cls_t                   mem_reg [stcs_pkg::QDEPTH];
    logic [stcs_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [stcs_pkg::QPTR_BITS-1:0]   wr_ptr_next;
    logic [stcs_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [stcs_pkg::QPTR_BITS-1:0]   rd_ptr_next;
    logic [stcs_pkg::QCNT_BITS-1:0]   count_reg;
    logic [stcs_pkg::QCNT_BITS-1:0]   count_next;

    localparam logic [stcs_pkg::QPTR_BITS-1:0] PTR_LAST =
        stcs_pkg::QPTR_BITS'(stcs_pkg::QDEPTH - 1);
    localparam logic [stcs_pkg::QCNT_BITS-1:0] CNT_FULL =
        stcs_pkg::QCNT_BITS'(stcs_pkg::QDEPTH);

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.avail = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    as_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

    as_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.avail)
        else $error("pop from empty queue");

    as_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

endmodule

@@ hdl/stcs_back.sv @@
module stcs_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stcs_pkg::cls_t       head,
    input  stcs_pkg::q_stat_t    q_stat,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output stcs_pkg::result_t    result
);

    localparam int CB = stcs_pkg::COUNT_BITS;
    localparam int DB = stcs_pkg::DEPTH_BITS;
    localparam logic [CB-1:0] CNT_MAX = '1;
    localparam logic [DB-1:0] DEP_MAX = '1;

    logic [CB-1:0] nl_reg, nl_next, nl_upd;
    logic [CB-1:0] match_reg, match_next, match_upd;
    logic [DB-1:0] depth_reg, depth_next, depth_upd;
    logic [DB-1:0] peak_reg, peak_next, peak_upd;
    logic [CB:0]   match_sum;
    logic [CB-1:0] line_sat, cplx_sat;

    logic                result_valid_reg, result_valid_next;
    stcs_pkg::result_t   result_reg, result_next;
    logic                out_free;

    function automatic logic [31:0] clip32(input logic [CB-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic [15:0] clip16(input logic [DB-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    // only a final request needs the result register
    assign out_free     = !result_valid_reg || !result_stall;
    assign pop          = q_stat.avail && (out_free || !head.last);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        nl_upd = nl_reg;
        if (head.newline && nl_reg != CNT_MAX)
            nl_upd = nl_reg + 1'b1;

        match_sum = {1'b0, match_reg} + (CB + 1)'(head.hits);
        match_upd = match_sum[CB] ? CNT_MAX : match_sum[CB-1:0];

        depth_upd = depth_reg;
        if (head.open)
        begin
            if (depth_reg != DEP_MAX)
                depth_upd = depth_reg + 1'b1;
        end
        else if (head.close && depth_reg != '0)
            depth_upd = depth_reg - 1'b1;
        peak_upd = (depth_upd > peak_reg) ? depth_upd : peak_reg;

        line_sat = (nl_upd == CNT_MAX) ? CNT_MAX : nl_upd + 1'b1;
        cplx_sat = (match_upd == CNT_MAX) ? CNT_MAX : match_upd + 1'b1;

        nl_next           = nl_reg;
        match_next        = match_reg;
        depth_next        = depth_reg;
        peak_next         = peak_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (pop)
        begin
            if (head.last)
            begin
                nl_next                = '0;
                match_next             = '0;
                depth_next             = '0;
                peak_next              = '0;
                result_valid_next      = 1'b1;
                result_next.line_total = clip32(line_sat);
                result_next.complexity = clip32(cplx_sat);
                result_next.nest_peak  = clip16(peak_upd);
            end
            else
            begin
                nl_next    = nl_upd;
                match_next = match_upd;
                depth_next = depth_upd;
                peak_next  = peak_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_reg           <= '0;
            match_reg        <= '0;
            depth_reg        <= '0;
            peak_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            nl_reg           <= nl_next;
            match_reg        <= match_next;
            depth_reg        <= depth_next;
            peak_reg         <= peak_next;
            result_valid_reg <= result_valid_next;
        end
    end

    as_peak_ge_depth: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= depth_reg)
        else $error("peak depth below current depth");

    as_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(pop && head.last))
        else $error("result raised without a final character");

    as_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.last |=> nl_reg == '0 && match_reg == '0 && peak_reg == '0)
        else $error("state not cleared after final character");

endmodule

@@ hdl/source_text_complexity_scan.sv @@
// Channel  Dir  Handshake                    Payload
// char     in   char_valid / char_stall      char_req   (ch, last)
// result   out  result_valid / result_stall  result     (line_total, complexity, nest_peak)
//
// One character per cycle while char_stall is low; front classifies in its accept cycle.
// Classified requests pass a two-entry queue; the back stage updates counters
// and loads the result register, so result_valid rises once the final request
// has been popped from the queue by the back stage.
// char_stall rises only while the queue is full (a final request held behind
// a stalled result).
// rst_n clears history, counters, queue and result valid at once; no sweep.
module source_text_complexity_scan
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  stcs_pkg::char_t      char_req,
    output logic                 result_valid,
    input  logic                 result_stall,
    output stcs_pkg::result_t    result
);

    logic                push;
    logic                pop;
    stcs_pkg::cls_t      push_data;
    stcs_pkg::cls_t      head;
    stcs_pkg::q_stat_t   q_stat;

    assign char_stall = q_stat.full;

    stcs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_req   (char_req),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    stcs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    stcs_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_stat       (q_stat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 10;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              char_valid = 1'b0;
    logic              char_stall;
    stcs_pkg::char_t   char_req = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    stcs_pkg::result_t result;

    source_text_complexity_scan uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_req     (char_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int chars_sent     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // text statistics tracked per accepted request
    logic [47:0] recent_chars = '0;
    logic        amp_paired   = 1'b0;
    logic        bar_paired   = 1'b0;
    logic [31:0] newlines     = '0;
    logic [31:0] keyword_hits = '0;
    logic [15:0] depth_cur    = '0;
    logic [15:0] depth_peak   = '0;

    stcs_pkg::result_t pending_results[$];
    logic [7:0]        text_buf[$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? '1 : sum[31:0];
    endfunction

    task automatic append_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endtask

    task automatic scan_char(input stcs_pkg::char_t req);
        logic [55:0]       win;
        logic [31:0]       hits;
        stcs_pkg::result_t res;
        win  = {recent_chars, req.ch};
        hits = '0;
        if (win[15:0] == {stcs_pkg::CH_I, stcs_pkg::CH_F})
            hits++;
        if (win[55:0] == {stcs_pkg::CH_E, stcs_pkg::CH_L, stcs_pkg::CH_S, stcs_pkg::CH_E,
                          stcs_pkg::CH_SPACE, stcs_pkg::CH_I, stcs_pkg::CH_F})
            hits++;
        if (win[23:0] == {stcs_pkg::CH_F, stcs_pkg::CH_O, stcs_pkg::CH_R})
            hits++;
        if (win[39:0] == {stcs_pkg::CH_W, stcs_pkg::CH_H, stcs_pkg::CH_I,
                          stcs_pkg::CH_L, stcs_pkg::CH_E})
            hits++;
        if (win[31:0] == {stcs_pkg::CH_C, stcs_pkg::CH_A, stcs_pkg::CH_S, stcs_pkg::CH_E})
            hits++;
        if (win[39:0] == {stcs_pkg::CH_C, stcs_pkg::CH_A, stcs_pkg::CH_T,
                          stcs_pkg::CH_C, stcs_pkg::CH_H})
            hits++;
        if (win[7:0] == stcs_pkg::CH_QMARK)
            hits++;
        // a pair consumes both characters, so runs count floor(n/2)
        if (req.ch == stcs_pkg::CH_AMP && win[15:8] == stcs_pkg::CH_AMP && !amp_paired)
        begin
            hits++;
            amp_paired = 1'b1;
        end
        else
            amp_paired = 1'b0;
        if (req.ch == stcs_pkg::CH_BAR && win[15:8] == stcs_pkg::CH_BAR && !bar_paired)
        begin
            hits++;
            bar_paired = 1'b1;
        end
        else
            bar_paired = 1'b0;
        keyword_hits = add_sat32(keyword_hits, hits);
        if (req.ch == stcs_pkg::CH_NL)
            newlines = add_sat32(newlines, 32'd1);
        if (req.ch == stcs_pkg::CH_LBRACE)
        begin
            if (depth_cur != '1)
                depth_cur++;
            if (depth_cur > depth_peak)
                depth_peak = depth_cur;
        end
        else if (req.ch == stcs_pkg::CH_RBRACE && depth_cur != '0)
            depth_cur--;
        recent_chars = win[47:0];
        if (req.last)
        begin
            res.line_total = add_sat32(newlines, 32'd1);
            res.complexity = add_sat32(keyword_hits, 32'd1);
            res.nest_peak  = depth_peak;
            pending_results.insert(pending_results.size(), res);
            recent_chars = '0;
            amp_paired   = 1'b0;
            bar_paired   = 1'b0;
            newlines     = '0;
            keyword_hits = '0;
            depth_cur    = '0;
            depth_peak   = '0;
        end
    endtask

    // returns in the time step of the accepting edge
    task automatic send_char(input logic [7:0] c, input logic is_last);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_req   <= {c, is_last};
        do
            @(posedge clk);
        while (char_stall);
        scan_char({c, is_last});
        chars_sent++;
    endtask

    task automatic send_buffer();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
        send_buffer();
    endtask

    task automatic wait_for_results();
        char_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic add_token();
        string tok;
        case ($urandom_range(0, 23))
            0:  tok = "if";
            1:  tok = "else if";
            2:  tok = "for";
            3:  tok = "while";
            4:  tok = "case";
            5:  tok = "catch";
            6:  tok = "&&";
            7:  tok = "||";
            8:  tok = "?";
            9:  tok = "{";
            10: tok = "}";
            11: tok = "\n";
            12: tok = " ";
            13: tok = "&";
            14: tok = "|";
            15: tok = "els";
            16: tok = "whi";
            17: tok = "cat";
            18: tok = "else\nif";
            19: tok = "{{";
            20: tok = "}}";
            21: tok = "x = a ? b : c;";
            default:
            begin
                tok = "";
                append_byte(8'($urandom_range(0, 255)));
            end
        endcase
        for (int i = 0; i < tok.len(); i++)
            append_byte(tok[i]);
    endtask

    task automatic test_edge_bytes();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_nested_keyword();
        send_string("else if");
    endtask

    task automatic test_pair_runs();
        send_string("&&&||||?");
    endtask

    task automatic test_brace_floor();
        send_string("}{{}\n{");
    endtask

    task automatic test_random_texts(input int n_chars);
        int start;
        int n_tok;
        start = chars_sent;
        while (chars_sent - start < n_chars)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    n_tok = $urandom_range(1, 24);
                    for (int i = 0; i < n_tok; i++)
                        append_byte(8'($urandom_range(0, 255)));
                end
                2:
                    append_byte(8'($urandom_range(0, 255)));
                default:
                begin
                    n_tok = $urandom_range(1, 10);
                    for (int i = 0; i < n_tok; i++)
                        add_token();
                end
            endcase
            send_buffer();
            if ($urandom_range(0, 39) == 0)
                wait_for_results();
        end
    endtask

    always @(posedge clk)
    begin
        stcs_pkg::result_t want;
        result_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.line_total !== want.line_total)
                begin
                    $error("line_total expected %0d actual %0d",
                           want.line_total, result.line_total);
                    mismatch_count++;
                end
                if (result.complexity !== want.complexity)
                begin
                    $error("complexity expected %0d actual %0d",
                           want.complexity, result.complexity);
                    mismatch_count++;
                end
                if (result.nest_peak !== want.nest_peak)
                begin
                    $error("nest_peak expected %0d actual %0d",
                           want.nest_peak, result.nest_peak);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("source_text_complexity_scan verification failed");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 14;
        recv_stall_pct = 52;
        test_edge_bytes();
        test_nested_keyword();
        test_pair_runs();
        test_brace_floor();
        wait_for_results();
        test_random_texts(460);
        wait_for_results();

        send_idle_pct  = 52;
        recv_stall_pct = 14;
        test_random_texts(460);
        wait_for_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_texts(470);
        wait_for_results();

        if (mismatch_count == 0)
            $display("source_text_complexity_scan verification clean");
        else
            $display("source_text_complexity_scan verification failed");
        $finish;
    end

endmodule
